@@ sv/loget_pkg.sv @@
// loget_pkg: shared widths, register indexes and record types for the
// 5x5 laplacian-of-gaussian edge marker; no dependencies
`default_nettype none

package loget_pkg;

   // image limits and field widths
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int PIX_W        = 8;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int WREG_W       = 11;
   localparam int HREG_W       = 13;
   localparam int THR_W        = 13;
   localparam int RESP_W       = 14;
   localparam int LINES        = 4;
   localparam int WIN          = 5;
   localparam int WORD_W       = LINES * PIX_W;
   localparam int MIN_DIM      = 5;
   localparam int BORDER       = 2;

   // result queue
   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = FIFO_AW + 1;
   localparam int FLIGHT_W     = 2;

   // register port
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   // reset values of the registers
   localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd1024;
   localparam logic [THR_W-1:0]  THR_RESET    = 13'd255;

   // position of one pixel as it enters the pipeline
   typedef struct packed {
      logic [COL_W-1:0] addr;
      logic             emit;
      logic             last;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
   } pos_type;

   // one finished result
   typedef struct packed {
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             mark;
      logic             last;
   } rsp_type;

endpackage

`default_nettype wire

@@ sv/loget_ctrl.sv @@
// loget_ctrl: configuration registers and raster position counters
// depends on loget_pkg
`default_nettype none

module loget_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [loget_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [loget_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                accept,
   input  logic                                sof,
   output loget_pkg::pos_type                  pos,
   output logic signed [loget_pkg::THR_W-1:0]  threshold
);

   logic [loget_pkg::WREG_W-1:0] width_ff;
   logic [loget_pkg::HREG_W-1:0] height_ff;
   logic [loget_pkg::THR_W-1:0]  thr_ff;
   logic [loget_pkg::COL_W-1:0]  col_ff, col_in;
   logic [loget_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [loget_pkg::WREG_W-1:0] w_eff;
   logic [loget_pkg::HREG_W-1:0] h_eff;
   logic [loget_pkg::COL_W-1:0]  c_cur;
   logic [loget_pkg::ROW_W-1:0]  r_cur;
   logic                         col_end, row_end;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= loget_pkg::WIDTH_RESET;
         height_ff <= loget_pkg::HEIGHT_RESET;
         thr_ff    <= loget_pkg::THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            loget_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[loget_pkg::WREG_W-1:0];
            end
            loget_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[loget_pkg::HREG_W-1:0];
            end
            loget_pkg::CSR_EDGE_THRESHOLD: begin
               thr_ff <= csr_wdata[loget_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign threshold = $signed(thr_ff);

   // clamp dimensions, locate the current pixel, step the counters
   always_comb begin
      if (width_ff < loget_pkg::WREG_W'(loget_pkg::MIN_DIM))
         w_eff = loget_pkg::WREG_W'(loget_pkg::MIN_DIM);
      else if (width_ff > loget_pkg::WREG_W'(loget_pkg::MAX_WIDTH))
         w_eff = loget_pkg::WREG_W'(loget_pkg::MAX_WIDTH);
      else
         w_eff = width_ff;

      if (height_ff < loget_pkg::HREG_W'(loget_pkg::MIN_DIM))
         h_eff = loget_pkg::HREG_W'(loget_pkg::MIN_DIM);
      else if (height_ff > loget_pkg::HREG_W'(loget_pkg::MAX_HEIGHT))
         h_eff = loget_pkg::HREG_W'(loget_pkg::MAX_HEIGHT);
      else
         h_eff = height_ff;

      c_cur = sof ? '0 : col_ff;
      r_cur = sof ? '0 : row_ff;

      col_end = ({1'b0, c_cur} >= (w_eff - 1'b1));
      row_end = ({1'b0, r_cur} >= (h_eff - 1'b1));

      pos.addr    = c_cur;
      pos.emit    = (r_cur >= loget_pkg::ROW_W'(2 * loget_pkg::BORDER)) &&
                    (c_cur >= loget_pkg::COL_W'(2 * loget_pkg::BORDER));
      pos.last    = ({1'b0, r_cur} == (h_eff - 1'b1)) &&
                    ({1'b0, c_cur} == (w_eff - 1'b1));
      pos.out_row = r_cur - loget_pkg::ROW_W'(loget_pkg::BORDER);
      pos.out_col = c_cur - loget_pkg::COL_W'(loget_pkg::BORDER);

      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : r_cur + 1'b1;
      end else begin
         col_in = c_cur + 1'b1;
         row_in = r_cur;
      end
   end

   // position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/loget_line_mem.sv @@
// loget_line_mem: four packed line buffers, one word per column, with
// read-during-write forwarding; depends on loget_pkg
`default_nettype none

module loget_line_mem (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [loget_pkg::COL_W-1:0]       rd_addr,
   input  logic                              wr_en,
   input  logic [loget_pkg::COL_W-1:0]       wr_addr,
   input  logic [loget_pkg::WORD_W-1:0]      wr_data,
   output logic [loget_pkg::WORD_W-1:0]      rd_data
);

   logic [loget_pkg::WORD_W-1:0] mem [loget_pkg::MAX_WIDTH];
   logic [loget_pkg::WORD_W-1:0] rd_q_ff;
   logic [loget_pkg::WORD_W-1:0] fwd_data_ff;
   logic                         fwd_ff;

   // storage: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_q_ff <= mem[rd_addr];
   end

   // a read that hits the column being written this cycle takes the new word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule

`default_nettype wire

@@ sv/loget_filter.sv @@
// loget_filter: line buffer write-back, 5x5 window, laplacian-of-gaussian
// sums and threshold compare; depends on loget_pkg
`default_nettype none

module loget_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [loget_pkg::PIX_W-1:0]         pixel,
   input  loget_pkg::pos_type                  pos,
   input  logic signed [loget_pkg::THR_W-1:0]  threshold,
   input  logic [loget_pkg::WORD_W-1:0]        rd_data,
   output logic                                wr_en,
   output logic [loget_pkg::COL_W-1:0]         wr_addr,
   output logic [loget_pkg::WORD_W-1:0]        wr_data,
   output logic                                push,
   output loget_pkg::rsp_type                  push_data,
   output logic [loget_pkg::FLIGHT_W-1:0]      in_flight
);

   localparam int P = loget_pkg::PIX_W;
   localparam int N = loget_pkg::WIN;
   localparam int C = loget_pkg::BORDER;

   // stage 1: column word returns from memory
   logic                        v1_ff;
   logic [P-1:0]                pix1_ff;
   loget_pkg::pos_type          pos1_ff;
   // stage 2: window holds this item's neighborhood
   logic                        v2_ff;
   loget_pkg::pos_type          pos2_ff;
   // stage 3: partial sums
   logic                        v3_ff;
   loget_pkg::pos_type          pos3_ff;
   logic [P-1:0]                ctr_ff;
   logic [P+1:0]                ax_ff;
   logic [P+2:0]                oth_ff;

   logic [P-1:0]                win_ff [N][N];
   logic [P-1:0]                win_in [N][N];
   logic [P-1:0]                column [N];
   logic [P+1:0]                ax_in;
   logic [P+2:0]                oth_in;
   logic signed [loget_pkg::RESP_W-1:0] resp;

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff <= pixel;
         pos1_ff <= pos;
      end
      pos2_ff <= pos1_ff;
      pos3_ff <= pos2_ff;
   end

   // shift the line buffers up by one row and append the new pixel
   always_comb begin
      for (int i = 0; i < loget_pkg::LINES; i++)
         column[i] = rd_data[i*P +: P];
      column[N-1] = pix1_ff;
      wr_en   = v1_ff;
      wr_addr = pos1_ff.addr;
      wr_data = {pix1_ff, rd_data[loget_pkg::WORD_W-1:P]};
   end

   // window shift: oldest column leaves at index 0
   always_comb begin
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N - 1; j++)
            win_in[i][j] = win_ff[i][j+1];
         win_in[i][N-1] = column[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
               win_ff[i][j] <= '0;
      end else if (v1_ff) begin
         win_ff <= win_in;
      end
   end

   // partial sums: near axis taps, and diagonal plus far axis taps
   always_comb begin
      ax_in  = (P+2)'(win_ff[C-1][C]) + (P+2)'(win_ff[C+1][C]) +
               (P+2)'(win_ff[C][C-1]) + (P+2)'(win_ff[C][C+1]);
      oth_in = ((P+3)'(win_ff[C-1][C-1]) + (P+3)'(win_ff[C-1][C+1])) +
               ((P+3)'(win_ff[C+1][C-1]) + (P+3)'(win_ff[C+1][C+1])) +
               ((P+3)'(win_ff[0][C])     + (P+3)'(win_ff[N-1][C])) +
               ((P+3)'(win_ff[C][0])     + (P+3)'(win_ff[C][N-1]));
   end

   always_ff @(posedge clock) begin
      ctr_ff <= win_ff[C][C];
      ax_ff  <= ax_in;
      oth_ff <= oth_in;
   end

   // response = 16*centre - 2*near - others, then compare
   always_comb begin
      resp = $signed({2'b00, ctr_ff, 4'b0000}) -
             $signed({3'b000, ax_ff, 1'b0}) -
             $signed({3'b000, oth_ff});
      push              = v3_ff && pos3_ff.emit;
      push_data.out_row = pos3_ff.out_row;
      push_data.out_col = pos3_ff.out_col;
      push_data.mark    = (resp > loget_pkg::RESP_W'(threshold));
      push_data.last    = pos3_ff.last;
   end

   // results still on their way to the queue
   assign in_flight = loget_pkg::FLIGHT_W'(v1_ff && pos1_ff.emit) +
                      loget_pkg::FLIGHT_W'(v2_ff && pos2_ff.emit) +
                      loget_pkg::FLIGHT_W'(v3_ff && pos3_ff.emit);

endmodule

`default_nettype wire

@@ sv/loget_out_fifo.sv @@
// loget_out_fifo: small result queue between the filter and the output
// channel; depends on loget_pkg
`default_nettype none

module loget_out_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  loget_pkg::rsp_type                   push_data,
   input  logic                                 pop,
   output logic                                 not_empty,
   output loget_pkg::rsp_type                   head,
   output logic [loget_pkg::FIFO_CNT_W-1:0]     count
);

   loget_pkg::rsp_type                  slot_ff [loget_pkg::FIFO_DEPTH];
   logic [loget_pkg::FIFO_AW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [loget_pkg::FIFO_CNT_W-1:0]    count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

@@ sv/log_edge_threshold_5x5_top.sv @@
// log_edge_threshold_5x5_top: top level of the 5x5 edge marker
// depends on loget_pkg, loget_ctrl, loget_line_mem, loget_filter, loget_out_fifo
`default_nettype none

// Takes one 8-bit pixel per clock in raster order when not stalled and marks
// edges with a 5x5 laplacian-of-gaussian response compared against
// edge_threshold. The four previous rows live in one 1024 x 32 line memory
// (one packed word per column) that is read when a pixel is taken and
// written back in the next cycle, so a new pixel can be taken every clock
// unless stalled. Results are registered through the filter pipeline before
// they enter the output queue; pixels within two rows or columns of a border
// give no result. The eight-entry output queue lets the input keep flowing
// while results wait; input stalls only when the queue plus results still in the pipeline would fill it.

module log_edge_threshold_5x5_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [loget_pkg::PIX_W-1:0]          req_pixel,
   input  logic                                 req_start_of_frame,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [loget_pkg::ROW_W-1:0]          rsp_out_row,
   output logic [loget_pkg::COL_W-1:0]          rsp_out_col,
   output logic [loget_pkg::PIX_W-1:0]          rsp_edge_pixel,
   output logic                                 rsp_last_of_frame,
   input  logic                                 csr_we,
   input  logic [loget_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [loget_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                                accept;
   loget_pkg::pos_type                  pos;
   logic signed [loget_pkg::THR_W-1:0]  threshold;
   logic [loget_pkg::WORD_W-1:0]        rd_data;
   logic                                wr_en;
   logic [loget_pkg::COL_W-1:0]         wr_addr;
   logic [loget_pkg::WORD_W-1:0]        wr_data;
   logic                                push;
   loget_pkg::rsp_type                  push_data;
   logic [loget_pkg::FLIGHT_W-1:0]      in_flight;
   logic                                pop;
   logic                                not_empty;
   loget_pkg::rsp_type                  head;
   logic [loget_pkg::FIFO_CNT_W-1:0]    count;
   logic [loget_pkg::FIFO_CNT_W:0]      reserved;

   // flow control: keep room in the queue for every result in flight
   assign reserved  = (loget_pkg::FIFO_CNT_W+1)'(count) +
                      (loget_pkg::FIFO_CNT_W+1)'(in_flight);
   assign req_stall = (reserved >= (loget_pkg::FIFO_CNT_W+1)'(loget_pkg::FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign pop       = not_empty && !rsp_stall;

   loget_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .sof       (req_start_of_frame),
      .pos       (pos),
      .threshold (threshold)
   );

   loget_line_mem u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pos.addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   loget_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pixel     (req_pixel),
      .pos       (pos),
      .threshold (threshold),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push      (push),
      .push_data (push_data),
      .in_flight (in_flight)
   );

   loget_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head),
      .count     (count)
   );

   // result channel
   assign rsp_valid         = not_empty;
   assign rsp_out_row       = head.out_row;
   assign rsp_out_col       = head.out_col;
   assign rsp_edge_pixel    = {loget_pkg::PIX_W{head.mark}};
   assign rsp_last_of_frame = head.last;

endmodule

`default_nettype wire

@@ sv/loget_checker.sv @@
// loget_checker: port-level checks on the edge marker's result channel
// depends on loget_pkg; bound to log_edge_threshold_5x5_top
`default_nettype none

module loget_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [loget_pkg::ROW_W-1:0]          rsp_out_row,
   input  logic [loget_pkg::COL_W-1:0]          rsp_out_col,
   input  logic [loget_pkg::PIX_W-1:0]          rsp_edge_pixel,
   input  logic                                 rsp_last_of_frame
);

   // the marker is all ones or all zeros
   a_mark_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_edge_pixel == '0 || rsp_edge_pixel == '1))
      else $error("edge pixel neither 0 nor 255");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a result centre never lies on the two-pixel border
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_row >= loget_pkg::ROW_W'(loget_pkg::BORDER) &&
                     rsp_out_col >= loget_pkg::COL_W'(loget_pkg::BORDER)))
      else $error("result centre on the border");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid && rsp_stall)) |-> rsp_valid)
      else $error("result withdrawn while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid && rsp_stall)) |->
         ($stable(rsp_out_row) && $stable(rsp_out_col) &&
          $stable(rsp_edge_pixel) && $stable(rsp_last_of_frame)))
      else $error("result payload changed while stalled");

endmodule

bind log_edge_threshold_5x5_top loget_checker u_loget_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_row       (rsp_out_row),
   .rsp_out_col       (rsp_out_col),
   .rsp_edge_pixel    (rsp_edge_pixel),
   .rsp_last_of_frame (rsp_last_of_frame)
);

`default_nettype wire

@@ test/tb.sv @@
// tb: self-checking bench for the 5x5 laplacian-of-gaussian edge marker
// keeps its own raster model of line store, window and position to predict marks
// depends on loget_pkg and log_edge_threshold_5x5_top
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [loget_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 250;

   // one input transfer and one predicted mark
   typedef struct packed {
      logic [loget_pkg::PIX_W-1:0] pixel;
      logic                        sof;
   } pixel_item_type;

   typedef struct packed {
      logic [loget_pkg::ROW_W-1:0] row;
      logic [loget_pkg::COL_W-1:0] col;
      logic [loget_pkg::PIX_W-1:0] mark;
      logic                        last;
   } edge_mark_type;

   logic                             clock;
   logic                             reset              = 1'b1;
   logic                             req_valid          = 1'b0;
   logic                             req_stall;
   logic [loget_pkg::PIX_W-1:0]      req_pixel          = '0;
   logic                             req_start_of_frame = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall          = 1'b0;
   logic [loget_pkg::ROW_W-1:0]      rsp_out_row;
   logic [loget_pkg::COL_W-1:0]      rsp_out_col;
   logic [loget_pkg::PIX_W-1:0]      rsp_edge_pixel;
   logic                             rsp_last_of_frame;
   logic                             csr_we             = 1'b0;
   logic [loget_pkg::CSR_IDX_W-1:0]  csr_index          = '0;
   logic [loget_pkg::CSR_DATA_W-1:0] csr_wdata          = '0;

   log_edge_threshold_5x5_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel          (req_pixel),
      .req_start_of_frame (req_start_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_edge_pixel     (rsp_edge_pixel),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // stimulus and expectation stores
   pixel_item_type pixel_queue [$];
   edge_mark_type  pending_marks [$];
   pixel_item_type next_pixel;
   edge_mark_type  oldest_mark;
   int             error_count = 0;
   int unsigned    cycle_count = 0;

   // idling controls, written by the sequencer only
   int idle_odds = 6;
   bit hold_go   = 1'b0;

   // driver and monitor private counters
   int send_gap   = 0;
   int stall_left = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   // mirrored registers and raster state
   logic [loget_pkg::WREG_W-1:0]       cfg_width     = loget_pkg::WIDTH_RESET;
   logic [loget_pkg::HREG_W-1:0]       cfg_height    = loget_pkg::HEIGHT_RESET;
   logic signed [loget_pkg::THR_W-1:0] cfg_threshold = loget_pkg::THR_RESET;
   bit [loget_pkg::PIX_W-1:0]  line_copy [loget_pkg::LINES][loget_pkg::MAX_WIDTH];
   int                         win [loget_pkg::WIN][loget_pkg::WIN];
   int                         row_pos = 0;
   int                         col_pos = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // raster model: shift one pixel in, predict the mark for centre (r-2, c-2)
   function automatic void predict_mark(input logic [loget_pkg::PIX_W-1:0] px,
                                        input logic sof);
      int column [loget_pkg::WIN];
      int w, h, r, c, resp, thr;
      edge_mark_type m;
      w = (cfg_width < loget_pkg::MIN_DIM) ? loget_pkg::MIN_DIM :
          ((cfg_width > loget_pkg::MAX_WIDTH) ? loget_pkg::MAX_WIDTH : int'(cfg_width));
      h = (cfg_height < loget_pkg::MIN_DIM) ? loget_pkg::MIN_DIM :
          ((cfg_height > loget_pkg::MAX_HEIGHT) ? loget_pkg::MAX_HEIGHT : int'(cfg_height));
      thr = int'(cfg_threshold);
      if (sof) begin
         row_pos = 0;
         col_pos = 0;
      end
      r = row_pos;
      c = col_pos % loget_pkg::MAX_WIDTH;
      // column of the four stored rows plus the new pixel
      for (int i = 0; i < loget_pkg::LINES; i++) begin
         column[i] = int'(line_copy[i][c]);
      end
      column[loget_pkg::LINES] = int'(px);
      for (int i = 0; i < loget_pkg::LINES - 1; i++) begin
         line_copy[i][c] = line_copy[i+1][c];
      end
      line_copy[loget_pkg::LINES-1][c] = px;
      for (int i = 0; i < loget_pkg::WIN; i++) begin
         for (int j = 0; j < loget_pkg::WIN - 1; j++) begin
            win[i][j] = win[i][j+1];
         end
         win[i][loget_pkg::WIN-1] = column[i];
      end
      // interior centre gives a mark
      if (r >= 4 && col_pos >= 4) begin
         resp = 16 * win[2][2]
              - 2 * (win[1][2] + win[3][2] + win[2][1] + win[2][3])
              - (win[1][1] + win[1][3] + win[3][1] + win[3][3])
              - (win[0][2] + win[4][2] + win[2][0] + win[2][4]);
         m.row  = loget_pkg::ROW_W'(r - 2);
         m.col  = loget_pkg::COL_W'(col_pos - 2);
         m.mark = (resp > thr) ? 8'd255 : 8'd0;
         m.last = (r == h - 1 && col_pos == w - 1);
         pending_marks.push_back(m);
      end
      // advance position, wrapping at row and frame end
      if (col_pos >= w - 1) begin
         col_pos = 0;
         row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   // driver: predict on each accepted transfer, then offer the next pixel
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_mark(req_pixel, req_start_of_frame);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (idle_odds != 0 && pixel_queue.size() != 0 &&
                         $urandom_range(1, idle_odds) == 1) begin
               send_gap = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               next_pixel = pixel_queue.pop_front();
               req_valid          <= 1'b1;
               req_pixel          <= next_pixel.pixel;
               req_start_of_frame <= next_pixel.sof;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted mark, then choose the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_marks.size() == 0) begin
               error_count = error_count + 1;
               if (error_count <= 10)
                  $display("mismatch: unexpected mark row %0d col %0d value %0d last %0d",
                           rsp_out_row, rsp_out_col, rsp_edge_pixel, rsp_last_of_frame);
            end else begin
               oldest_mark = pending_marks.pop_front();
               if (rsp_out_row !== oldest_mark.row || rsp_out_col !== oldest_mark.col ||
                   rsp_edge_pixel !== oldest_mark.mark ||
                   rsp_last_of_frame !== oldest_mark.last) begin
                  error_count = error_count + 1;
                  if (error_count <= 10)
                     $display({"mismatch: expected row %0d col %0d value %0d last %0d,",
                               " got %0d %0d %0d %0d"},
                              oldest_mark.row, oldest_mark.col, oldest_mark.mark,
                              oldest_mark.last, rsp_out_row, rsp_out_col,
                              rsp_edge_pixel, rsp_last_of_frame);
               end
            end
         end
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // register write, mirrored into the model
   task automatic write_reg(input logic [loget_pkg::CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[loget_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         loget_pkg::CSR_IMAGE_WIDTH:    cfg_width     = value[loget_pkg::WREG_W-1:0];
         loget_pkg::CSR_IMAGE_HEIGHT:   cfg_height    = value[loget_pkg::HREG_W-1:0];
         loget_pkg::CSR_EDGE_THRESHOLD: cfg_threshold = value[loget_pkg::THR_W-1:0];
         default: ;
      endcase
   endtask

   // wait until every pixel is taken and every mark has come, then let the pipe empty
   task automatic wait_drained();
      while (pixel_queue.size() != 0 || req_valid || pending_marks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [loget_pkg::PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return loget_pkg::PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int rand_threshold();
      int t;
      t = $urandom_range(0, 600);
      return t - 300;
   endfunction

   // random raster content, optional start of frame on the first pixel and as noise
   task automatic queue_pixels(input int count, input bit sof_first, input int sof_odds);
      pixel_item_type it;
      for (int k = 0; k < count; k++) begin
         it.pixel = rand_pixel();
         it.sof   = (k == 0 && sof_first) || (sof_odds != 0 && $urandom_range(1, sof_odds) == 1);
         pixel_queue.push_back(it);
      end
   endtask

   // 10x5 frame: bright centre at (2,2) for the largest response,
   // dark centre at (2,7) ringed by bright taps for the smallest
   task automatic queue_directed(input bit sof_first);
      pixel_item_type it;
      int ring_span;
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 10; c++) begin
            ring_span = ((r > 2) ? r - 2 : 2 - r) + ((c > 7) ? c - 7 : 7 - c);
            it.pixel = ((r == 2 && c == 2) || (ring_span >= 1 && ring_span <= 2)) ?
                       8'd255 : 8'd0;
            it.sof   = sof_first && r == 0 && c == 0;
            pixel_queue.push_back(it);
         end
      end
   endtask

   // sequencer
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: response extremes against thresholds one below the largest and above the smallest
      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 10);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 5);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, 4079);
      write_reg(CSR_SPARE_INDEX, 13'h1abc);
      queue_directed(1'b1);
      wait_drained();
      // second frame follows the end-of-frame wrap with no start of frame
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, -3060);
      queue_directed(1'b0);
      wait_drained();

      // dimensions below the minimum clamp to 5
      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 0);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 3);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, rand_threshold());
      queue_pixels(75, 1'b1, 0);
      wait_drained();

      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 8);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 7);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, rand_threshold());
      queue_pixels(112, 1'b1, 0);
      wait_drained();

      // threshold equal to the smallest response marks every other response
      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 13);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 9);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, -4080);
      queue_pixels(117, 1'b1, 0);
      wait_drained();

      // tallest frame, threshold equal to the largest response marks nothing; stop mid-row
      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 6);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 4096);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, 4080);
      queue_pixels(151, 1'b1, 0);
      wait_drained();

      // registers changed within the frame: narrower rows, height clamps high
      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 5);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 8191);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, rand_threshold());
      queue_pixels(100, 1'b1, 0);
      wait_drained();

      // width above the maximum clamps; only part of the first row
      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 2047);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 5);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, rand_threshold());
      queue_pixels(100, 1'b1, 0);
      wait_drained();

      // stray starts of frame, most negative raw threshold
      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 7);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 6);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, -4096);
      queue_pixels(150, 1'b1, 30);
      wait_drained();

      // most positive raw threshold
      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 11);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 8);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, 4095);
      queue_pixels(176, 1'b1, 0);
      wait_drained();

      // receiver holds off long enough to back up the input
      idle_odds = 3;
      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 9);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 12);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, rand_threshold());
      hold_go = 1'b1;
      queue_pixels(300, 1'b1, 0);
      wait_drained();

      // full rate on both sides to the end
      idle_odds = 0;
      write_reg(loget_pkg::CSR_IMAGE_WIDTH, 12);
      write_reg(loget_pkg::CSR_IMAGE_HEIGHT, 10);
      write_reg(loget_pkg::CSR_EDGE_THRESHOLD, rand_threshold());
      queue_pixels(240, 1'b1, 0);
      wait_drained();

      error_count = error_count + pending_marks.size();
      if (error_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
